@@ design/rms_frame_level_gate_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the frame RMS level gate
// Clocked property checks shared by the block's modules, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RMS_FRAME_LEVEL_GATE_CORE_ASSERT_SVH
`define RMS_FRAME_LEVEL_GATE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFLG_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFLG_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/rflg_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame RMS level gate package
// Widths, limits and the frame record passed from the front to the back.
// ----------------------------------------------------------------------------
package rflg_pkg;

  localparam int MAX_FRAME   = 1024;
  localparam int SAMPLE_W    = 16;
  localparam int SQUARE_W    = 2 * SAMPLE_W - 1;
  localparam int SUM_W       = SQUARE_W + $clog2(MAX_FRAME);
  localparam int COUNT_W     = $clog2(MAX_FRAME + 1);
  localparam int LEVEL_W     = 16;
  localparam int RAD_W       = 2 * LEVEL_W;
  localparam int REM_W       = LEVEL_W + 2;
  localparam int STEP_W      = $clog2(SUM_W + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = LEVEL_W'(3277);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX       = LEVEL_W'(32768);

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
    logic               overflow;
  } frame_t;

endpackage

@@ design/rflg_front.sv @@
// ----------------------------------------------------------------------------
// Frame RMS level gate front end
// Squares each sample, keeps the frame sum, count and drop mark, and hands a
// finished frame record onward on the last sample.
// ----------------------------------------------------------------------------
`include "rms_frame_level_gate_core_assert.svh"

module rflg_front import rflg_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       frame_end,
  output logic                       frame_valid,
  output frame_t                     frame
);

  logic [SUM_W-1:0]            square_sum;
  logic [COUNT_W-1:0]          sample_count;
  logic                        overflow_seen;
  logic signed [2*SAMPLE_W-1:0] product;
  logic [SQUARE_W-1:0]         square;
  logic                        at_limit;
  logic [SUM_W-1:0]            square_sum_next;
  logic [COUNT_W-1:0]          sample_count_next;
  logic                        overflow_seen_next;

  assign product  = sample * sample;
  assign square   = product[SQUARE_W-1:0];
  assign at_limit = (sample_count == COUNT_W'(MAX_FRAME));

  always_comb begin
    if (at_limit) begin
      square_sum_next   = square_sum;
      sample_count_next = sample_count;
    end else begin
      square_sum_next   = square_sum + SUM_W'(square);
      sample_count_next = sample_count + COUNT_W'(1);
    end
    overflow_seen_next = overflow_seen | at_limit;
  end

  assign frame_valid    = accept & frame_end;
  assign frame.sum      = square_sum_next;
  assign frame.count    = sample_count_next;
  assign frame.overflow = overflow_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum    <= '0;
      sample_count  <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (frame_end) begin
        square_sum    <= '0;
        sample_count  <= '0;
        overflow_seen <= 1'b0;
      end else begin
        square_sum    <= square_sum_next;
        sample_count  <= sample_count_next;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

  `RFLG_ASSERT_IMPL(a_count_limit, accept, sample_count <= COUNT_W'(MAX_FRAME), "Sample count passed the frame limit.")

endmodule

@@ design/rflg_queue.sv @@
// ----------------------------------------------------------------------------
// Frame RMS level gate frame queue
// Short queue of finished frame records between the front and the back end.
// ----------------------------------------------------------------------------
`include "rms_frame_level_gate_core_assert.svh"

module rflg_queue import rflg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t push_data,
  output logic   full,
  input  logic   pop,
  output frame_t pop_data,
  output logic   empty
);

  frame_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] fill;

  assign full     = (fill == QCOUNT_W'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCOUNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCOUNT_W'(1);
      end
    end
  end

  `RFLG_ASSERT_NEXT(a_fill_up, push && !pop, fill == $past(fill) + QCOUNT_W'(1), "Queue fill did not rise on a push.")
  `RFLG_ASSERT_NEXT(a_fill_down, pop && !push, fill == $past(fill) - QCOUNT_W'(1), "Queue fill did not fall on a pop.")

endmodule

@@ design/rflg_back.sv @@
// ----------------------------------------------------------------------------
// Frame RMS level gate back end
// Divides the frame sum by the count one bit per cycle, takes the integer
// root two bits per cycle, and holds the level in the output register.
// ----------------------------------------------------------------------------
`include "rms_frame_level_gate_core_assert.svh"

module rflg_back import rflg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  frame_t             entry,
  input  logic               entry_empty,
  output logic               entry_pop,
  input  logic               out_pop,
  output logic               out_valid,
  output logic [LEVEL_W-1:0] level,
  output logic               overflow
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_DONE = 4'b1000
  } back_state_t;

  back_state_t          state;
  logic [STEP_W-1:0]    step;
  logic [SUM_W-1:0]     dividend;
  logic [COUNT_W-1:0]   divisor;
  logic [COUNT_W-1:0]   rem_div;
  logic                 overflow_hold;
  logic [RAD_W-1:0]     radicand;
  logic [REM_W-1:0]     rem_root;
  logic [LEVEL_W-1:0]   root;

  logic [COUNT_W:0]     div_trial;
  logic [COUNT_W:0]     div_diff;
  logic                 div_ge;
  logic [COUNT_W-1:0]   rem_div_next;
  logic [SUM_W-1:0]     quotient_next;
  logic [REM_W+1:0]     root_trial;
  logic [REM_W+1:0]     root_test;
  logic [REM_W+1:0]     root_diff;
  logic                 root_ge;
  logic [REM_W-1:0]     rem_root_next;
  logic [LEVEL_W-1:0]   root_next;
  logic                 out_load;

  assign div_trial     = {rem_div, dividend[SUM_W-1]};
  assign div_diff      = div_trial - {1'b0, divisor};
  assign div_ge        = (div_trial >= {1'b0, divisor});
  assign rem_div_next  = div_ge ? div_diff[COUNT_W-1:0] : div_trial[COUNT_W-1:0];
  assign quotient_next = {dividend[SUM_W-2:0], div_ge};

  assign root_trial    = {rem_root, radicand[RAD_W-1 -: 2]};
  assign root_test     = {2'b00, root, 2'b01};
  assign root_diff     = root_trial - root_test;
  assign root_ge       = (root_trial >= root_test);
  assign rem_root_next = root_ge ? root_diff[REM_W-1:0] : root_trial[REM_W-1:0];
  assign root_next     = {root[LEVEL_W-2:0], root_ge};

  assign entry_pop = (state == ST_IDLE) && !entry_empty;
  assign out_load  = (state == ST_DONE) && (!out_valid || out_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!entry_empty) begin
            state <= ST_DIV;
            step  <= '0;
          end
        end
        ST_DIV: begin
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= ST_ROOT;
            step  <= '0;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_ROOT: begin
          if (step == STEP_W'(LEVEL_W - 1)) begin
            state <= ST_DONE;
            step  <= '0;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
          step  <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (entry_pop) begin
      dividend      <= entry.sum;
      divisor       <= entry.count;
      overflow_hold <= entry.overflow;
      rem_div       <= '0;
    end
    if (state == ST_DIV) begin
      dividend <= quotient_next;
      rem_div  <= rem_div_next;
      if (step == STEP_W'(SUM_W - 1)) begin
        radicand <= (divisor == '0) ? '0 : quotient_next[RAD_W-1:0];
        rem_root <= '0;
        root     <= '0;
      end
    end
    if (state == ST_ROOT) begin
      radicand <= {radicand[RAD_W-3:0], 2'b00};
      rem_root <= rem_root_next;
      root     <= root_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      level    <= root;
      overflow <= overflow_hold;
    end
  end

  `RFLG_ASSERT_IMPL(a_div_rem, (state == ST_DIV) && (divisor != '0), rem_div < divisor, "Divider remainder reached the divisor.")
  `RFLG_ASSERT_IMPL(a_level_range, out_load, root <= LEVEL_MAX, "Root level above full scale.")

endmodule

@@ design/rms_frame_level_gate_core.sv @@
// ----------------------------------------------------------------------------
// Frame RMS level gate
// Accumulates squared samples per frame and, for each frame closed by its
// last sample, reports integer RMS level, threshold and dropped-sample flags.
// ----------------------------------------------------------------------------
//  Channel   Signals                                     Handshake
//  input     sample, frame_end                           push / full
//  result    rms_level, above_threshold, frame_overflow  pop / empty
//  config    cfg_wdata (level_threshold)                 cfg_we
//
// A sample is taken every cycle while the frame queue has room.
// Each frame then leaves the queue, runs through the divider and the root
// steps and is loaded into the result register; the one-bit-per-cycle
// divider takes most of that time. The back end works on one frame at a time.
// Two finished frames can wait in the queue while the back end is busy.
// The result register holds its item until popped; the back end waits on it.
// Reset clears all control state and sets the threshold to 3277.
// ----------------------------------------------------------------------------
module rms_frame_level_gate_core import rflg_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       frame_end,
  output logic                       empty,
  input  logic                       pop,
  output logic [LEVEL_W-1:0]         rms_level,
  output logic                       above_threshold,
  output logic                       frame_overflow,
  input  logic                       cfg_we,
  input  logic [LEVEL_W-1:0]         cfg_wdata
);

  logic [LEVEL_W-1:0] level_threshold;
  logic               accept;
  logic               frame_valid;
  frame_t             frame;
  frame_t             queue_head;
  logic               queue_empty;
  logic               queue_pop;
  logic               out_valid;
  logic               out_pop;

  assign accept  = push & ~full;
  assign empty   = ~out_valid;
  assign out_pop = pop & out_valid;
  assign above_threshold = (rms_level > level_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      level_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      level_threshold <= cfg_wdata;
    end
  end

  rflg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .sample      (sample),
    .frame_end   (frame_end),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  rflg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (frame_valid),
    .push_data (frame),
    .full      (full),
    .pop       (queue_pop),
    .pop_data  (queue_head),
    .empty     (queue_empty)
  );

  rflg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (queue_head),
    .entry_empty (queue_empty),
    .entry_pop   (queue_pop),
    .out_pop     (out_pop),
    .out_valid   (out_valid),
    .level       (rms_level),
    .overflow    (frame_overflow)
  );

endmodule
